### hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MEM_UNITS = 1024;
    localparam int MAX_LVL   = $clog2(MEM_UNITS);
    localparam int LVL_W     = $clog2(MAX_LVL + 1);
    localparam int NODE_W    = MAX_LVL + 1;
    localparam int NODES     = 2 * MEM_UNITS;
    localparam int ADDR_W    = 10;
    localparam int OWNER_W   = 16;
    localparam int REQ_W     = 11;
    localparam int STAT_W    = 2;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // level of a node = position of its leading one
    function automatic logic [LVL_W-1:0] msb_pos(input logic [NODE_W-1:0] n);
        logic [LVL_W-1:0] p;
        p = '0;
        for (int i = 0; i < NODE_W; i++) begin
            if (n[i]) p = LVL_W'(i);
        end
        return p;
    endfunction

    // start address: push the leading one to the top and drop it
    function automatic logic [ADDR_W-1:0] start_of(input logic [NODE_W-1:0] n,
                                                   input logic [LVL_W-1:0]  lvl);
        logic [NODE_W-1:0] t;
        t = NODE_W'(n << (LVL_W'(MAX_LVL) - lvl));
        return t[ADDR_W-1:0];
    endfunction

endpackage

### hdl/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator; split/allocated/owner state held in two RAMs.
// ----------------------------------------------------------------------------
// Allocate: one node checked per cycle, up to 2047 nodes in two passes, then
//   one split write per split level and one write; bad sizes answered in S_IDLE.
// Free: nodes walked via S_FRD/S_FEV, one clear write, S_MRD1/S_MRD2/S_MCHK
//   per ancestor merge. The result strobe o_valid rises the cycle after the
// state that sets it (on a free S_FCLR, ahead of the merges); the receiver
// cannot stall. After reset a clearing pass over all 2048 nodes runs, busy high.
module buddy_block_allocator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [bba_pkg::OWNER_W-1:0] i_owner_id,
    input  logic [bba_pkg::REQ_W-1:0]   i_request_size,
    output logic                        o_valid,
    output logic [bba_pkg::ADDR_W-1:0]  o_address,
    output logic [bba_pkg::STAT_W-1:0]  o_status
);

    localparam int NW = bba_pkg::NODE_W;
    localparam int LW = bba_pkg::LVL_W;
    localparam int AW = bba_pkg::OWNER_W + 1;  // {alloc, owner}

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_SCAN = 11'b00000000100,
        S_SPLT = 11'b00000001000,
        S_AWR  = 11'b00000010000,
        S_FRD  = 11'b00000100000,
        S_FEV  = 11'b00001000000,
        S_FCLR = 11'b00010000000,
        S_MRD1 = 11'b00100000000,
        S_MRD2 = 11'b01000000000,
        S_MCHK = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // split flags: one write, two reads
    logic s_mem [bba_pkg::NODES];
    logic          s_we, s_wd;
    logic [NW-1:0] s_wa, s_ra, s_rb;
    logic          r_s_qa, r_s_qb;

    // allocated flag and owner
    logic [AW-1:0] a_mem [bba_pkg::NODES];
    logic          a_we;
    logic [AW-1:0] a_wd, r_a_q;
    logic [NW-1:0] a_wa, a_ra;

    always_ff @(posedge i_clk) begin
        if (s_we) s_mem[s_wa] <= s_wd;
        r_s_qa <= s_mem[s_ra];
        r_s_qb <= s_mem[s_rb];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) a_mem[a_wa] <= a_wd;
        r_a_q <= a_mem[a_ra];
    end

    // control
    logic [NW-1:0] r_clr, n_clr;
    logic          r_valid, n_valid;
    logic          r_iss, n_iss, r_ev_vld, n_ev_vld;
    // payload
    logic [bba_pkg::OWNER_W-1:0] r_own, n_own;
    logic [bba_pkg::REQ_W-1:0]   r_req, n_req;
    logic [LW-1:0] r_d, n_d, r_plvl, n_plvl, r_nlvl, n_nlvl;
    logic [NW-1:0] r_idx, n_idx, r_end, n_end, r_ev_idx, n_ev_idx;
    logic [NW-1:0] r_pick, n_pick, r_n, n_n, r_m, n_m;
    logic          r_dir, n_dir, r_ev_last, n_ev_last;
    logic          r_ls, n_ls, r_rs, n_rs, r_la, n_la;
    logic [bba_pkg::ADDR_W-1:0] r_oaddr, n_oaddr;
    logic [bba_pkg::STAT_W-1:0] r_ostat, n_ostat;

    // size class of the request
    logic [LW-1:0] req_lvl;
    always_comb begin
        req_lvl = '0;
        for (int k = 1; k <= bba_pkg::MAX_LVL; k++) begin
            if (bba_pkg::REQ_W'(bba_pkg::MEM_UNITS >> k) >= i_request_size)
                req_lvl = req_lvl + LW'(1);
        end
    end

    logic          ev_free, fr_hit, fr_desc, z_found;
    logic [LW-1:0] z_pos, ev_lvl;
    logic [bba_pkg::REQ_W-1:0] half;

    always_comb begin
        ev_free = (r_ev_idx == NW'(1)) ? (!r_s_qa && !r_a_q[AW-1])
                                       : (r_s_qb && !r_s_qa && !r_a_q[AW-1]);
        ev_lvl  = bba_pkg::msb_pos(r_ev_idx);
        half    = bba_pkg::REQ_W'(bba_pkg::MEM_UNITS / 2) >> r_nlvl;
        fr_hit  = r_a_q[AW-1] && (r_a_q[AW-2:0] == r_own);
        fr_desc = r_s_qa && (half >= r_req) && (r_nlvl < LW'(bba_pkg::MAX_LVL));
        // lowest zero below the leading one ends the climb
        z_found = 1'b0;
        z_pos   = '0;
        for (int i = 0; i < NW; i++) begin
            if (!z_found && (LW'(i) < r_nlvl) && !r_n[i]) begin
                z_found = 1'b1;
                z_pos   = LW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;  n_clr = r_clr;  n_valid = 1'b0;
        n_iss = r_iss;  n_ev_vld = r_ev_vld;
        n_own = r_own;  n_req = r_req;  n_d = r_d;  n_plvl = r_plvl;
        n_nlvl = r_nlvl;  n_idx = r_idx;  n_end = r_end;  n_ev_idx = r_ev_idx;
        n_pick = r_pick;  n_n = r_n;  n_m = r_m;  n_dir = r_dir;
        n_ev_last = r_ev_last;  n_ls = r_ls;  n_rs = r_rs;  n_la = r_la;
        n_oaddr = r_oaddr;  n_ostat = r_ostat;
        s_we = 1'b0;  s_wd = 1'b0;  s_wa = r_pick;
        a_we = 1'b0;  a_wd = '0;    a_wa = r_pick;
        s_ra = r_idx;  s_rb = r_idx >> 1;  a_ra = r_idx;

        unique case (r_state)
            S_CLR: begin
                s_we = 1'b1;  s_wa = r_clr;
                a_we = 1'b1;  a_wa = r_clr;
                n_clr = r_clr + NW'(1);
                if (r_clr == NW'(bba_pkg::NODES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_own = i_owner_id;
                    n_req = i_request_size;
                    if (i_command == bba_pkg::CMD_ALLOC) begin
                        if (i_request_size == '0 ||
                            i_request_size > bba_pkg::REQ_W'(bba_pkg::MEM_UNITS)) begin
                            n_valid = 1'b1;  n_oaddr = '0;  n_ostat = bba_pkg::ST_NO_SPACE;
                        end else begin
                            n_d      = req_lvl;
                            n_idx    = NW'(1) << req_lvl;
                            n_end    = (NW'(2) << req_lvl) - NW'(1);
                            n_dir    = 1'b0;
                            n_iss    = 1'b1;
                            n_ev_vld = 1'b0;
                            n_state  = S_SCAN;
                        end
                    end else begin
                        n_n = NW'(1);  n_nlvl = '0;  n_state = S_FRD;
                    end
                end
            end
            S_SCAN: begin
                // issue one node per cycle, check it the cycle after
                if (r_iss) begin
                    n_ev_vld  = 1'b1;
                    n_ev_idx  = r_idx;
                    n_ev_last = (r_idx == r_end);
                    if (r_idx == r_end) n_iss = 1'b0;
                    n_idx = r_dir ? r_idx - NW'(1) : r_idx + NW'(1);
                end else begin
                    n_ev_vld = 1'b0;
                end
                if (r_ev_vld && ev_free) begin
                    n_pick  = r_ev_idx;
                    n_plvl  = ev_lvl;
                    n_state = (ev_lvl < r_d) ? S_SPLT : S_AWR;
                end else if (r_ev_vld && r_ev_last) begin
                    if (!r_dir && r_d != '0) begin
                        // larger blocks: all shallower levels, right to left
                        n_dir    = 1'b1;
                        n_idx    = (NW'(1) << r_d) - NW'(1);
                        n_end    = NW'(1);
                        n_iss    = 1'b1;
                        n_ev_vld = 1'b0;
                    end else begin
                        n_valid = 1'b1;  n_oaddr = '0;  n_ostat = bba_pkg::ST_NO_SPACE;
                        n_state = S_IDLE;
                    end
                end
            end
            S_SPLT: begin
                s_we = 1'b1;  s_wd = 1'b1;  s_wa = r_pick;
                n_pick = r_pick << 1;
                n_plvl = r_plvl + LW'(1);
                if (r_plvl + LW'(1) == r_d) n_state = S_AWR;
            end
            S_AWR: begin
                a_we = 1'b1;  a_wa = r_pick;  a_wd = {1'b1, r_own};
                n_valid = 1'b1;
                n_oaddr = bba_pkg::start_of(r_pick, r_plvl);
                n_ostat = bba_pkg::ST_OK;
                n_state = S_IDLE;
            end
            S_FRD: begin
                s_ra = r_n;  a_ra = r_n;
                n_state = S_FEV;
            end
            S_FEV: begin
                if (fr_hit) begin
                    n_pick = r_n;  n_plvl = r_nlvl;  n_state = S_FCLR;
                end else if (fr_desc) begin
                    n_n = r_n << 1;  n_nlvl = r_nlvl + LW'(1);  n_state = S_FRD;
                end else if (z_found) begin
                    n_n     = (r_n >> z_pos) | NW'(1);
                    n_nlvl  = r_nlvl - z_pos;
                    n_state = S_FRD;
                end else begin
                    n_valid = 1'b1;  n_oaddr = '0;  n_ostat = bba_pkg::ST_NOT_FOUND;
                    n_state = S_IDLE;
                end
            end
            S_FCLR: begin
                a_we = 1'b1;  a_wa = r_pick;  a_wd = '0;
                n_valid = 1'b1;
                n_oaddr = bba_pkg::start_of(r_pick, r_plvl);
                n_ostat = bba_pkg::ST_OK;
                n_m = r_pick >> 1;
                n_state = (r_pick == NW'(1)) ? S_IDLE : S_MRD1;
            end
            S_MRD1: begin
                s_ra = {r_m[NW-2:0], 1'b0};
                s_rb = {r_m[NW-2:0], 1'b1};
                a_ra = {r_m[NW-2:0], 1'b0};
                n_state = S_MRD2;
            end
            S_MRD2: begin
                s_ra = r_m;
                a_ra = {r_m[NW-2:0], 1'b1};
                n_ls = r_s_qa;  n_rs = r_s_qb;  n_la = r_a_q[AW-1];
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (r_s_qa && !r_ls && !r_rs && !r_la && !r_a_q[AW-1]) begin
                    s_we = 1'b1;  s_wd = 1'b0;  s_wa = r_m;
                end
                n_m = r_m >> 1;
                n_state = (r_m == NW'(1)) ? S_IDLE : S_MRD1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_valid  <= 1'b0;
            r_iss    <= 1'b0;
            r_ev_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_valid  <= n_valid;
            r_iss    <= n_iss;
            r_ev_vld <= n_ev_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_own <= n_own;  r_req <= n_req;  r_d <= n_d;  r_plvl <= n_plvl;
        r_nlvl <= n_nlvl;  r_idx <= n_idx;  r_end <= n_end;  r_ev_idx <= n_ev_idx;
        r_pick <= n_pick;  r_n <= n_n;  r_m <= n_m;  r_dir <= n_dir;
        r_ev_last <= n_ev_last;  r_ls <= n_ls;  r_rs <= n_rs;  r_la <= n_la;
        r_oaddr <= n_oaddr;  r_ostat <= n_ostat;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_address = r_oaddr;
    assign o_status  = r_ostat;

endmodule

### hdl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [bba_pkg::ADDR_W-1:0]  o_address,
    input logic [bba_pkg::STAT_W-1:0]  o_status
);

    // an accepted transaction either answers at once or keeps the block busy
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transaction neither busy nor answered");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == bba_pkg::ST_OK || o_status == bba_pkg::ST_NO_SPACE ||
                     o_status == bba_pkg::ST_NOT_FOUND))
        else $error("illegal status code");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bba_pkg::ST_OK) |-> (o_address == '0))
        else $error("failed transaction with nonzero address");

    // clearing pass holds the block busy right after reset
    a_rst_busy: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> busy)
        else $error("not busy after reset");

    a_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && busy) |=> !o_valid)
        else $error("second result while still busy");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_address (o_address),
    .o_status  (o_status)
);
